FILE: src/uvs_pkg.sv
// uvs_pkg: shared types, constants and tables of the uv sphere vertex generator
// no dependencies
package uvs_pkg;

  localparam int MAX_SEGMENTS = 256;
  localparam int SEG_W        = 9;
  localparam int RAD_W        = 16;
  localparam int POS_W        = 17;
  localparam int TEX_W        = 17;
  localparam int IDX_W        = 17;

  // divider: integer bit plus fractional bits, a few per stage
  localparam int DIV_ST   = 7;
  localparam int DIV_STEP = 4;
  localparam int DIV_QW   = 1 + DIV_ST * DIV_STEP;

  // cordic: q4.30 datapath, two rotations per stage
  localparam int COR_ITER = 16;
  localparam int COR_STEP = 2;
  localparam int COR_ST   = COR_ITER / COR_STEP;
  localparam int COR_XW   = 34;
  localparam int COR_ZW   = 25;
  localparam int TURN_W   = 24;
  localparam logic signed [COR_XW-1:0] COR_GAIN = 34'sd652032874;

  localparam logic signed [COR_ZW-1:0] ARC [COR_ITER] = '{
    25'sd2097152, 25'sd1238021, 25'sd654136, 25'sd332050,
    25'sd166669,  25'sd83416,   25'sd41718,  25'sd20860,
    25'sd10430,   25'sd5215,    25'sd2608,   25'sd1304,
    25'sd652,     25'sd326,     25'sd163,    25'sd81
  };

  // pipeline stage map
  localparam int STG_DIV0 = 1;
  localparam int STG_ANG  = STG_DIV0 + DIV_ST;
  localparam int STG_COR0 = STG_ANG + 1;
  localparam int STG_SCL0 = STG_COR0 + COR_ST;
  localparam int SCL_ST   = 4;
  localparam int NST      = STG_SCL0 + SCL_ST;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_RADIUS = 2'd0,
    REG_XSEG   = 2'd1,
    REG_YSEG   = 2'd2
  } reg_idx_t;

  // per-transaction data that travels beside the arithmetic
  typedef struct packed {
    logic             quad;
    logic [IDX_W-1:0] idx0;
    logic [IDX_W-1:0] idx1;
    logic [TEX_W-1:0] tex_u;
    logic [TEX_W-1:0] tex_v;
    logic             flip_t;
    logic             flip_p;
  } side_t;

  // segment count limited to 1 .. MAX_SEGMENTS
  function automatic logic [SEG_W-1:0] seg_count(input logic [SEG_W-1:0] r);
    logic [SEG_W-1:0] c;
    c = r;
    if (r == '0) c = SEG_W'(1);
    else if (r > SEG_W'(MAX_SEGMENTS)) c = SEG_W'(MAX_SEGMENTS);
    return c;
  endfunction

endpackage

FILE: src/uvs_div.sv
// uvs_div: pipelined restoring divider, num / den as a binary fraction
// depends on uvs_pkg; num never exceeds den
module uvs_div (
  input  logic                           clk,
  input  logic [uvs_pkg::DIV_ST-1:0]     en,
  input  logic [uvs_pkg::SEG_W-1:0]      num,
  input  logic [uvs_pkg::SEG_W-1:0]      den,
  output logic [uvs_pkg::DIV_QW-1:0]     quo
);

  logic [uvs_pkg::SEG_W-1:0]  rem_r [uvs_pkg::DIV_ST];
  logic [uvs_pkg::DIV_QW-1:0] quo_r [uvs_pkg::DIV_ST];

  for (genvar k = 0; k < uvs_pkg::DIV_ST; k++) begin : g_stage
    logic [uvs_pkg::SEG_W-1:0]  rem_nxt;
    logic [uvs_pkg::DIV_QW-1:0] quo_nxt;

    // integer bit in the first stage, then a few fraction bits per stage
    always_comb begin
      logic [uvs_pkg::SEG_W:0] r2;
      logic                    b;
      if (k == 0) begin
        b       = (num >= den);
        quo_nxt = uvs_pkg::DIV_QW'(b);
        rem_nxt = b ? '0 : num;
      end else begin
        quo_nxt = quo_r[(k == 0) ? 0 : k-1];
        rem_nxt = rem_r[(k == 0) ? 0 : k-1];
      end
      for (int j = 0; j < uvs_pkg::DIV_STEP; j++) begin
        r2 = {rem_nxt, 1'b0};
        b  = (r2 >= {1'b0, den});
        rem_nxt = b ? uvs_pkg::SEG_W'(r2 - {1'b0, den}) : r2[uvs_pkg::SEG_W-1:0];
        quo_nxt = {quo_nxt[uvs_pkg::DIV_QW-2:0], b};
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem_r[k] <= rem_nxt;
        quo_r[k] <= quo_nxt;
      end
    end
  end

  assign quo = quo_r[uvs_pkg::DIV_ST-1];

endmodule

FILE: src/uvs_cordic.sv
// uvs_cordic: pipelined rotation cordic giving scaled cos and sin
// depends on uvs_pkg; angle already folded into a quarter turn either side
module uvs_cordic (
  input  logic                                clk,
  input  logic [uvs_pkg::COR_ST-1:0]          en,
  input  logic signed [uvs_pkg::COR_ZW-1:0]   z_in,
  output logic signed [uvs_pkg::COR_XW-1:0]   x_out,
  output logic signed [uvs_pkg::COR_XW-1:0]   y_out
);

  logic signed [uvs_pkg::COR_XW-1:0] x_r [uvs_pkg::COR_ST];
  logic signed [uvs_pkg::COR_XW-1:0] y_r [uvs_pkg::COR_ST];
  logic signed [uvs_pkg::COR_ZW-1:0] z_r [uvs_pkg::COR_ST];

  for (genvar k = 0; k < uvs_pkg::COR_ST; k++) begin : g_stage
    logic signed [uvs_pkg::COR_XW-1:0] x_nxt, y_nxt;
    logic signed [uvs_pkg::COR_ZW-1:0] z_nxt;

    // two micro-rotations per stage
    always_comb begin
      logic signed [uvs_pkg::COR_XW-1:0] nx;
      if (k == 0) begin
        x_nxt = uvs_pkg::COR_GAIN;
        y_nxt = '0;
        z_nxt = z_in;
      end else begin
        x_nxt = x_r[(k == 0) ? 0 : k-1];
        y_nxt = y_r[(k == 0) ? 0 : k-1];
        z_nxt = z_r[(k == 0) ? 0 : k-1];
      end
      for (int j = 0; j < uvs_pkg::COR_STEP; j++) begin
        if (z_nxt >= 0) begin
          nx    = x_nxt - (y_nxt >>> (k * uvs_pkg::COR_STEP + j));
          y_nxt = y_nxt + (x_nxt >>> (k * uvs_pkg::COR_STEP + j));
          z_nxt = z_nxt - uvs_pkg::ARC[k * uvs_pkg::COR_STEP + j];
        end else begin
          nx    = x_nxt + (y_nxt >>> (k * uvs_pkg::COR_STEP + j));
          y_nxt = y_nxt - (x_nxt >>> (k * uvs_pkg::COR_STEP + j));
          z_nxt = z_nxt + uvs_pkg::ARC[k * uvs_pkg::COR_STEP + j];
        end
        x_nxt = nx;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        x_r[k] <= x_nxt;
        y_r[k] <= y_nxt;
        z_r[k] <= z_nxt;
      end
    end
  end

  assign x_out = x_r[uvs_pkg::COR_ST-1];
  assign y_out = y_r[uvs_pkg::COR_ST-1];

endmodule

FILE: src/uvs_scale.sv
// uvs_scale: rounds cordic outputs to q1.15 and scales them by the radius
// depends on uvs_pkg; four register stages
module uvs_scale (
  input  logic                                clk,
  input  logic [uvs_pkg::SCL_ST-1:0]          en,
  input  logic signed [uvs_pkg::COR_XW-1:0]   ct_in,
  input  logic signed [uvs_pkg::COR_XW-1:0]   st_in,
  input  logic signed [uvs_pkg::COR_XW-1:0]   cp_in,
  input  logic signed [uvs_pkg::COR_XW-1:0]   sp_in,
  input  logic                                flip_t,
  input  logic                                flip_p,
  input  logic [uvs_pkg::RAD_W-1:0]           radius,
  output logic signed [uvs_pkg::POS_W-1:0]    pos_x,
  output logic signed [uvs_pkg::POS_W-1:0]    pos_y,
  output logic signed [uvs_pkg::POS_W-1:0]    pos_z
);

  // round half up to q1.15, negate on half-turn fold, saturate
  function automatic logic signed [15:0] to_q15(input logic signed [33:0] v,
                                                input logic flip);
    logic signed [33:0] s;
    logic signed [18:0] t;
    s = v + 34'sd16384;
    t = s[33:15];
    if (flip) t = -t;
    if (t > 19'sd32767) t = 19'sd32767;
    else if (t < -19'sd32767) t = -19'sd32767;
    return t[15:0];
  endfunction

  logic signed [15:0] ct_r, st_r, cp_r, sp_r;
  logic signed [31:0] ctsp_r, stsp_r;
  logic signed [32:0] rcp_r;
  logic signed [48:0] pxp_r, pzp_r;
  logic signed [uvs_pkg::POS_W-1:0] py_r, py2_r, px_r, pz_r;
  logic signed [16:0] rad_s;
  logic signed [32:0] py_sum;
  logic signed [17:0] py_sh;
  logic signed [48:0] px_sum, pz_sum;
  logic signed [18:0] px_sh, pz_sh;

  assign rad_s = $signed({1'b0, radius});

  // rounding of the rotation results
  always_ff @(posedge clk) begin
    if (en[0]) begin
      ct_r <= to_q15(ct_in, flip_t);
      st_r <= to_q15(st_in, flip_t);
      cp_r <= to_q15(cp_in, flip_p);
      sp_r <= to_q15(sp_in, flip_p);
    end
  end

  // first products
  always_ff @(posedge clk) begin
    if (en[1]) begin
      ctsp_r <= 32'(ct_r) * 32'(sp_r);
      stsp_r <= 32'(st_r) * 32'(sp_r);
      rcp_r  <= 33'(rad_s) * 33'(cp_r);
    end
  end

  // radius products and latitude result
  assign py_sum = rcp_r + 33'sd16384;
  assign py_sh  = py_sum[32:15];
  always_ff @(posedge clk) begin
    if (en[2]) begin
      pxp_r <= 49'(rad_s) * 49'(ctsp_r);
      pzp_r <= 49'(rad_s) * 49'(stsp_r);
      if (py_sh > 18'sd65535) py_r <= 17'sd65535;
      else if (py_sh < -18'sd65535) py_r <= -17'sd65535;
      else py_r <= py_sh[16:0];
    end
  end

  // final rounding and saturation
  assign px_sum = pxp_r + 49'sd536870912;
  assign pz_sum = pzp_r + 49'sd536870912;
  assign px_sh  = px_sum[48:30];
  assign pz_sh  = pz_sum[48:30];
  always_ff @(posedge clk) begin
    if (en[3]) begin
      py2_r <= py_r;
      if (px_sh > 19'sd65535) px_r <= 17'sd65535;
      else if (px_sh < -19'sd65535) px_r <= -17'sd65535;
      else px_r <= px_sh[16:0];
      if (pz_sh > 19'sd65535) pz_r <= 17'sd65535;
      else if (pz_sh < -19'sd65535) pz_r <= -17'sd65535;
      else pz_r <= pz_sh[16:0];
    end
  end

  assign pos_x = px_r;
  assign pos_y = py2_r;
  assign pos_z = pz_r;

endmodule

FILE: src/uv_sphere_vertex_generator.sv
// uv_sphere_vertex_generator: top level, grid point in, vertex and quad out
// depends on uvs_pkg, uvs_div, uvs_cordic, uvs_scale
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | grid_x, grid_y
//  out_    | output    | out_valid/out_stall| position, texture, quad indices
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_wdata
//
// one transaction per cycle while out_stall is low; out_valid rises once a point has passed the
// 21 register stages: clamp, 7-stage divider, angle fold, 8-stage cordic, 4-stage scaling
// every stage holds a valid bit; a stage loads when empty or moving on, so
// bubbles close up under out_stall and input is taken while a result waits
// synchronous active-low reset clears valid bits and sets configuration to its defaults
module uv_sphere_vertex_generator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [uvs_pkg::SEG_W-1:0]        in_grid_x,
  input  logic [uvs_pkg::SEG_W-1:0]        in_grid_y,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [uvs_pkg::POS_W-1:0] out_pos_x,
  output logic signed [uvs_pkg::POS_W-1:0] out_pos_y,
  output logic signed [uvs_pkg::POS_W-1:0] out_pos_z,
  output logic [uvs_pkg::TEX_W-1:0]        out_tex_u,
  output logic [uvs_pkg::TEX_W-1:0]        out_tex_v,
  output logic                             out_quad_valid,
  output logic [uvs_pkg::IDX_W-1:0]        out_tri0_a,
  output logic [uvs_pkg::IDX_W-1:0]        out_tri0_b,
  output logic [uvs_pkg::IDX_W-1:0]        out_tri0_c,
  output logic [uvs_pkg::IDX_W-1:0]        out_tri1_a,
  output logic [uvs_pkg::IDX_W-1:0]        out_tri1_b,
  output logic [uvs_pkg::IDX_W-1:0]        out_tri1_c,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [1:0]                       cfg_index,
  input  logic [15:0]                      cfg_wdata
);

  localparam int N = uvs_pkg::NST;

  logic [uvs_pkg::RAD_W-1:0] radius_r;
  logic [uvs_pkg::SEG_W-1:0] xseg_r, yseg_r, xs, ys;
  logic [N-1:0]              v_r;
  logic [N:0]                load;
  logic [uvs_pkg::SEG_W-1:0] gx_r, gy_r;
  logic                      quad_r;
  uvs_pkg::side_t            sb_r [uvs_pkg::STG_DIV0:N-1];
  logic [uvs_pkg::DIV_QW-1:0] qx, qy;
  logic signed [uvs_pkg::COR_ZW-1:0] zt_r, zp_r;
  logic signed [uvs_pkg::COR_XW-1:0] ct, st, cp, sp;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= uvs_pkg::RAD_W'(256);
      xseg_r   <= uvs_pkg::SEG_W'(32);
      yseg_r   <= uvs_pkg::SEG_W'(16);
    end else if (cfg_valid && cfg_ready) begin
      case (uvs_pkg::reg_idx_t'(cfg_index))
        uvs_pkg::REG_RADIUS: radius_r <= cfg_wdata;
        uvs_pkg::REG_XSEG:   xseg_r   <= cfg_wdata[uvs_pkg::SEG_W-1:0];
        uvs_pkg::REG_YSEG:   yseg_r   <= cfg_wdata[uvs_pkg::SEG_W-1:0];
        default: ;
      endcase
    end
  end

  assign xs = uvs_pkg::seg_count(xseg_r);
  assign ys = uvs_pkg::seg_count(yseg_r);

  // stage load chain, closing bubbles back from the output
  always_comb begin
    load[N] = !out_stall;
    for (int k = N-1; k >= 0; k--) load[k] = !v_r[k] || load[k+1];
  end
  assign in_stall  = !load[0];
  assign out_valid = v_r[N-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (load[0]) v_r[0] <= in_valid;
      for (int k = 1; k < N; k++) begin
        if (load[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // clamp grid point to the segment counts
  always_ff @(posedge clk) begin
    if (load[0]) begin
      gx_r   <= (in_grid_x > xs) ? xs : in_grid_x;
      gy_r   <= (in_grid_y > ys) ? ys : in_grid_y;
      quad_r <= (in_grid_x < xs) && (in_grid_y < ys);
    end
  end

  uvs_div u_div_x (
    .clk (clk),
    .en  (load[uvs_pkg::STG_ANG-1:uvs_pkg::STG_DIV0]),
    .num (gx_r),
    .den (xs),
    .quo (qx)
  );

  uvs_div u_div_y (
    .clk (clk),
    .en  (load[uvs_pkg::STG_ANG-1:uvs_pkg::STG_DIV0]),
    .num (gy_r),
    .den (ys),
    .quo (qy)
  );

  // quad indices beside the first divider stage
  uvs_pkg::side_t sb_first;
  always_comb begin
    logic [9:0]  w;
    logic [18:0] prod;
    logic [uvs_pkg::IDX_W-1:0] i0;
    w    = {1'b0, xs} + 10'd1;
    prod = 19'(gy_r) * 19'(w);
    i0   = uvs_pkg::IDX_W'(prod + 19'(gx_r));
    sb_first        = '0;
    sb_first.quad   = quad_r;
    sb_first.idx0   = quad_r ? i0 : '0;
    sb_first.idx1   = quad_r ? uvs_pkg::IDX_W'(i0 + uvs_pkg::IDX_W'(w)) : '0;
  end

  // fold a turn angle into a quarter turn either side of zero
  function automatic logic [uvs_pkg::COR_ZW:0] fold(
      input logic [uvs_pkg::TURN_W-1:0] a);
    logic signed [uvs_pkg::COR_ZW-1:0] z;
    logic flip;
    z    = $signed({1'b0, a});
    flip = 1'b0;
    if (a >= 24'h400000 && a < 24'hC00000) begin
      z    = z - 25'sh0800000;
      flip = 1'b1;
    end else if (a >= 24'hC00000) begin
      z = z - 25'sh1000000;
    end
    return {flip, z};
  endfunction

  // angles and texture coordinates from the quotients
  uvs_pkg::side_t sb_ang;
  logic [uvs_pkg::COR_ZW:0] ft, fp;
  always_comb begin
    logic [26:0] az;
    logic [25:0] po;
    logic [18:0] tu, tv;
    az = {1'b0, qx[28:3]} + 27'd1;
    po = {1'b0, qy[28:4]} + 26'd1;
    tu = {1'b0, qx[28:11]} + 19'd1;
    tv = {1'b0, qy[28:11]} + 19'd1;
    ft = fold(az[24:1]);
    fp = fold(po[24:1]);
    sb_ang        = sb_r[uvs_pkg::STG_ANG-1];
    sb_ang.tex_u  = tu[17:1];
    sb_ang.tex_v  = tv[17:1];
    sb_ang.flip_t = ft[uvs_pkg::COR_ZW];
    sb_ang.flip_p = fp[uvs_pkg::COR_ZW];
  end

  always_ff @(posedge clk) begin
    if (load[uvs_pkg::STG_ANG]) begin
      zt_r <= $signed(ft[uvs_pkg::COR_ZW-1:0]);
      zp_r <= $signed(fp[uvs_pkg::COR_ZW-1:0]);
    end
  end

  // side data shift line
  for (genvar k = uvs_pkg::STG_DIV0; k < N; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (load[k]) begin
        if (k == uvs_pkg::STG_DIV0) sb_r[k] <= sb_first;
        else if (k == uvs_pkg::STG_ANG) sb_r[k] <= sb_ang;
        else sb_r[k] <= sb_r[(k == uvs_pkg::STG_DIV0) ? k : k-1];
      end
    end
  end

  uvs_cordic u_cor_t (
    .clk   (clk),
    .en    (load[uvs_pkg::STG_SCL0-1:uvs_pkg::STG_COR0]),
    .z_in  (zt_r),
    .x_out (ct),
    .y_out (st)
  );

  uvs_cordic u_cor_p (
    .clk   (clk),
    .en    (load[uvs_pkg::STG_SCL0-1:uvs_pkg::STG_COR0]),
    .z_in  (zp_r),
    .x_out (cp),
    .y_out (sp)
  );

  uvs_scale u_scale (
    .clk    (clk),
    .en     (load[N-1:uvs_pkg::STG_SCL0]),
    .ct_in  (ct),
    .st_in  (st),
    .cp_in  (cp),
    .sp_in  (sp),
    .flip_t (sb_r[uvs_pkg::STG_SCL0-1].flip_t),
    .flip_p (sb_r[uvs_pkg::STG_SCL0-1].flip_p),
    .radius (radius_r),
    .pos_x  (out_pos_x),
    .pos_y  (out_pos_y),
    .pos_z  (out_pos_z)
  );

  // result fields
  assign out_tex_u      = sb_r[N-1].tex_u;
  assign out_tex_v      = sb_r[N-1].tex_v;
  assign out_quad_valid = sb_r[N-1].quad;
  assign out_tri0_a     = sb_r[N-1].idx1;
  assign out_tri0_b     = sb_r[N-1].idx0;
  assign out_tri0_c     = sb_r[N-1].quad ? sb_r[N-1].idx0 + 17'd1 : '0;
  assign out_tri1_a     = sb_r[N-1].idx1;
  assign out_tri1_b     = sb_r[N-1].quad ? sb_r[N-1].idx0 + 17'd1 : '0;
  assign out_tri1_c     = sb_r[N-1].quad ? sb_r[N-1].idx1 + 17'd1 : '0;

endmodule

FILE: src/uvs_checker.sv
// uvs_checker: port-level assertions for the uv sphere vertex generator
// depends on uv_sphere_vertex_generator ports; bound to the top level below
module uvs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [16:0] out_pos_x,
  input logic [16:0] out_tex_u,
  input logic [16:0] out_tex_v,
  input logic        out_quad_valid,
  input logic [16:0] out_tri0_a,
  input logic [16:0] out_tri0_b,
  input logic [16:0] out_tri0_c,
  input logic [16:0] out_tri1_a,
  input logic [16:0] out_tri1_b,
  input logic [16:0] out_tri1_c
);

  // a stalled result stays valid and keeps out_pos_x and out_tri0_a
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pos_x) && $stable(out_tri0_a))
    else $error("stalled result changed");

  // no quad means all indices zero
  a_noquad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_quad_valid |-> out_tri0_a == 17'd0 && out_tri0_b == 17'd0 &&
      out_tri0_c == 17'd0 && out_tri1_a == 17'd0 && out_tri1_b == 17'd0 &&
      out_tri1_c == 17'd0)
    else $error("indices without quad");

  // the two triangles share two corners, and tri0_c follows tri0_b
  a_share: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_quad_valid |-> out_tri0_a == out_tri1_a &&
      out_tri0_c == out_tri1_b && out_tri0_c == out_tri0_b + 17'd1)
    else $error("quad corners inconsistent");

  // texture coordinates within one
  a_tex: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_tex_u <= 17'd65536 && out_tex_v <= 17'd65536)
    else $error("texture coordinate above one");

endmodule

bind uv_sphere_vertex_generator uvs_checker u_chk (.*);

FILE: dv/uv_sphere_vertex_generator_tb.sv
// uv_sphere_vertex_generator_tb: self-checking testbench for the uv sphere vertex generator
// depends on uvs_pkg and the uv_sphere_vertex_generator rtl; drives grid points, checks vertices
`timescale 1ns / 100ps

module uv_sphere_vertex_generator_tb;

  localparam int TRI_N = 6;

  typedef struct {
    logic signed [uvs_pkg::POS_W-1:0] pos_x, pos_y, pos_z;
    logic [uvs_pkg::TEX_W-1:0]        tex_u, tex_v;
    logic                             quad;
    logic [uvs_pkg::IDX_W-1:0]        tri_idx [TRI_N];
  } vertex_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [uvs_pkg::SEG_W-1:0] in_grid_x = '0, in_grid_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [uvs_pkg::POS_W-1:0] out_pos_x, out_pos_y, out_pos_z;
  logic [uvs_pkg::TEX_W-1:0] out_tex_u, out_tex_v;
  logic out_quad_valid;
  logic [uvs_pkg::IDX_W-1:0] out_tri0_a, out_tri0_b, out_tri0_c;
  logic [uvs_pkg::IDX_W-1:0] out_tri1_a, out_tri1_b, out_tri1_c;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  // shadow of the configuration registers
  logic [uvs_pkg::RAD_W-1:0] radius_q = 16'd256;
  logic [uvs_pkg::SEG_W-1:0] xseg_q = 9'd32, yseg_q = 9'd16;

  vertex_t vertex_q[$];
  int  n_errors = 0;
  bit  in_idle_en = 1'b1, out_idle_en = 1'b1;

  uv_sphere_vertex_generator uut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // arithmetic shift with floor, as in the datapath
  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clip(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint seg_limit(logic [uvs_pkg::SEG_W-1:0] r);
    if (r == 0) return 1;
    if (r > uvs_pkg::MAX_SEGMENTS) return uvs_pkg::MAX_SEGMENTS;
    return r;
  endfunction

  // q1.15 cosine and sine of an angle in 2^-24 turn
  task automatic cordic_sincos(input longint ang, output longint c, output longint s);
    longint z, x, y, nx;
    longint arcs [16] = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718,
                          20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
    bit flip;
    z = ang & ((64'sd1 << 24) - 1);
    x = 652032874;
    y = 0;
    flip = 1'b0;
    if (z >= (1 << 22) && z < 3 * (1 << 22)) begin
      z -= (1 << 23);
      flip = 1'b1;
    end else if (z >= 3 * (1 << 22)) begin
      z -= (1 << 24);
    end
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - floor_shr(y, i);
        y = y + floor_shr(x, i);
        z -= arcs[i];
      end else begin
        nx = x + floor_shr(y, i);
        y = y - floor_shr(x, i);
        z += arcs[i];
      end
      x = nx;
    end
    x = floor_shr(x + (1 << 14), 15);
    y = floor_shr(y + (1 << 14), 15);
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = clip(x, 32767);
    s = clip(y, 32767);
  endtask

  // expected vertex for one grid point under the current configuration
  task automatic predict_vertex(input logic [uvs_pkg::SEG_W-1:0] gx_in, gy_in,
                                output vertex_t v);
    longint xs, ys, gx, gy, ct, st, cp, sp, r, w, i0, i1;
    xs = seg_limit(xseg_q);
    ys = seg_limit(yseg_q);
    gx = (gx_in > xs) ? xs : gx_in;
    gy = (gy_in > ys) ? ys : gy_in;
    v.tex_u = uvs_pkg::TEX_W'(((gx << 17) + xs) / (2 * xs));
    v.tex_v = uvs_pkg::TEX_W'(((gy << 17) + ys) / (2 * ys));
    cordic_sincos(((gx << 25) + xs) / (2 * xs), ct, st);
    cordic_sincos(((gy << 24) + ys) / (2 * ys), cp, sp);
    r = radius_q;
    v.pos_x = uvs_pkg::POS_W'(clip(floor_shr(r * ct * sp + (64'sd1 << 29), 30), 65535));
    v.pos_y = uvs_pkg::POS_W'(clip(floor_shr(r * cp + (1 << 14), 15), 65535));
    v.pos_z = uvs_pkg::POS_W'(clip(floor_shr(r * st * sp + (64'sd1 << 29), 30), 65535));
    v.quad = (gx < xs) && (gy < ys);
    w = xs + 1;
    i0 = gy * w + gx;
    i1 = (gy + 1) * w + gx;
    if (v.quad) begin
      v.tri_idx = '{uvs_pkg::IDX_W'(i1), uvs_pkg::IDX_W'(i0), uvs_pkg::IDX_W'(i0 + 1),
                    uvs_pkg::IDX_W'(i1), uvs_pkg::IDX_W'(i0 + 1), uvs_pkg::IDX_W'(i1 + 1)};
    end else begin
      v.tri_idx = '{default: '0};
    end
  endtask

  // send one grid point and queue its expected vertex
  task automatic send_point(input logic [uvs_pkg::SEG_W-1:0] gx, gy);
    vertex_t v;
    while (in_idle_en && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    predict_vertex(gx, gy, v);
    in_valid <= 1'b1;
    in_grid_x <= gx;
    in_grid_y <= gy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    vertex_q.push_back(v);
  endtask

  // wait until every vertex has come back, then let the pipeline drain
  task automatic drain;
    in_valid <= 1'b0;
    while (vertex_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(input uvs_pkg::reg_idx_t idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      uvs_pkg::REG_RADIUS: radius_q = data;
      uvs_pkg::REG_XSEG:   xseg_q = data[uvs_pkg::SEG_W-1:0];
      uvs_pkg::REG_YSEG:   yseg_q = data[uvs_pkg::SEG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] rad, input logic [15:0] xs, ys);
    drain();
    write_reg(uvs_pkg::REG_RADIUS, rad);
    write_reg(uvs_pkg::REG_XSEG, xs);
    write_reg(uvs_pkg::REG_YSEG, ys);
    cfg_valid <= 1'b0;
  endtask

  // extremes of both fields and grid corners under the reset configuration
  task automatic test_directed_extremes;
    send_point(0, 0);
    send_point(32, 16);
    send_point(31, 15);
    send_point(9'h1ff, 9'h1ff);
    send_point(8, 8);
    send_point(16, 4);
    send_point(24, 12);
    send_point(9'h155, 9'h0aa);
    send_point(9'h0aa, 9'h155);
  endtask

  // zero and oversized segment counts, full radius, largest quad indices
  task automatic test_directed_special;
    set_config(16'hffff, 0, 0);
    send_point(0, 0);
    send_point(1, 1);
    set_config(16'h0000, 16'h1ff, 16'h1ff);
    send_point(255, 255);
    send_point(256, 256);
    set_config(16'hffff, 256, 256);
    send_point(255, 255);
    send_point(128, 64);
    send_point(64, 128);
    send_point(192, 200);
  endtask

  // random grid points over a range of configurations
  task automatic test_random_points;
    int xs, ys;
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: set_config(16'd256, 32, 16);
        1: set_config(16'hffff, 1, 1);
        2: set_config(16'h8000, 256, 256);
        3: set_config(16'd0, 3, 7);
        default: set_config(16'($urandom), 16'($urandom_range(0, 511)),
                            16'($urandom_range(0, 511)));
      endcase
      // long stretch with no idling on either side
      in_idle_en = (phase != 5);
      out_idle_en = (phase != 5);
      xs = int'(seg_limit(xseg_q));
      ys = int'(seg_limit(yseg_q));
      for (int n = 0; n < 200; n++) begin
        if ($urandom_range(9) < 8) begin
          send_point(uvs_pkg::SEG_W'($urandom_range(0, xs)),
                     uvs_pkg::SEG_W'($urandom_range(0, ys)));
        end else begin
          send_point(uvs_pkg::SEG_W'($urandom), uvs_pkg::SEG_W'($urandom));
        end
      end
    end
    in_idle_en = 1'b1;
    out_idle_en = 1'b1;
  endtask

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= out_idle_en && ($urandom_range(99) < 35);
  end

  // compare each vertex with the oldest expectation
  always @(posedge clk) begin
    vertex_t e;
    logic [uvs_pkg::IDX_W-1:0] got [TRI_N];
    if (rst_n && out_valid && !out_stall) begin
      if (vertex_q.size() == 0) begin
        $error("unexpected vertex transaction");
        n_errors++;
      end else begin
        e = vertex_q.pop_front();
        got = '{out_tri0_a, out_tri0_b, out_tri0_c, out_tri1_a, out_tri1_b, out_tri1_c};
        if (out_pos_x !== e.pos_x) begin
          $error("pos_x exp %0d got %0d", e.pos_x, out_pos_x); n_errors++;
        end
        if (out_pos_y !== e.pos_y) begin
          $error("pos_y exp %0d got %0d", e.pos_y, out_pos_y); n_errors++;
        end
        if (out_pos_z !== e.pos_z) begin
          $error("pos_z exp %0d got %0d", e.pos_z, out_pos_z); n_errors++;
        end
        if (out_tex_u !== e.tex_u) begin
          $error("tex_u exp %0d got %0d", e.tex_u, out_tex_u); n_errors++;
        end
        if (out_tex_v !== e.tex_v) begin
          $error("tex_v exp %0d got %0d", e.tex_v, out_tex_v); n_errors++;
        end
        if (out_quad_valid !== e.quad) begin
          $error("quad_valid exp %0d got %0d", e.quad, out_quad_valid); n_errors++;
        end
        for (int i = 0; i < TRI_N; i++) begin
          if (got[i] !== e.tri_idx[i]) begin
            $error("tri%0d_%s exp %0d got %0d", i / 3, (i % 3 == 0) ? "a" :
                   (i % 3 == 1) ? "b" : "c", e.tri_idx[i], got[i]);
            n_errors++;
          end
        end
      end
    end
  end

  // test sequence
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_extremes();
    test_directed_special();
    test_random_points();
    drain();
    if (n_errors == 0 && vertex_q.size() == 0) begin
      $display("uv_sphere_vertex_generator_tb: clean");
    end else begin
      $display("uv_sphere_vertex_generator_tb: errors");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("uv_sphere_vertex_generator_tb: errors");
    $finish;
  end

endmodule
